// File: sv/hpq_pkg.sv
`timescale 1ns / 1ps

package hpq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int TOTAL_W     = 11;
    localparam int STATUS_W    = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]      raddr_a;
        logic [ADDR_W-1:0]      raddr_b;
    } ram_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   is_empty;
        logic [TOTAL_W-1:0]     element_total;
        logic [VALUE_WIDTH-1:0] top_value;
        logic [VALUE_WIDTH-1:0] popped_value;
    } res_t;

endpackage

// File: sv/binary_min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps

// Min-first priority queue of signed 32-bit values, up to 1024 entries.
// Input stream (s_*): one transfer is one operation, push of a value or pop
// of the smallest value. Output stream (m_*): exactly one result per
// operation, in order: popped value, new smallest value, count, empty flag
// and status (0 ok, 1 push refused when full, 2 pop refused when empty).
// Operations run one at a time; s_tready is high only while the sequencer
// is idle. The heap sits in a two-read-port RAM with registered reads and
// every level of a sift goes through one shared signed comparator.
// A push moves its value up one level at a time while it is less than its
// parent; a pop takes the last element to the root and sifts it down while
// its smaller child is less than it. Refused operations and a pop of the
// last element go straight to the result without a RAM pass. s_tready
// rises as the result is registered. A new operation may be taken while
// the previous result sits in the output register; if the receiver
// stalls, the next result waits in the sequencer and input is held off.
// Reset empties the queue; no clearing pass is needed.
module binary_min_heap_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode, push_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // popped_value, top_value, element_total, is_empty, status, zero pad
);

    hpq_pkg::ram_req_t               ram_req;
    logic [hpq_pkg::VALUE_WIDTH-1:0] rd_a;
    logic [hpq_pkg::VALUE_WIDTH-1:0] rd_b;
    logic [hpq_pkg::VALUE_WIDTH-1:0] cmp_a;
    logic [hpq_pkg::VALUE_WIDTH-1:0] cmp_b;
    logic                            cmp_less;
    hpq_pkg::res_t                   res;
    logic                            res_valid;
    logic                            res_ready;
    hpq_pkg::res_t                   out_reg;
    logic                            out_valid_reg;

    hpq_ram #(
        .WIDTH (hpq_pkg::VALUE_WIDTH),
        .DEPTH (hpq_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    hpq_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (cmp_less)
    );

    hpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tdata[0]),
        .in_value  (s_tdata[hpq_pkg::VALUE_WIDTH:1]),
        .ram_req   (ram_req),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_less  (cmp_less),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

// File: sv/hpq_ram.sv
`timescale 1ns / 1ps

module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: sv/hpq_cmp.sv
`timescale 1ns / 1ps

module hpq_cmp (
    input  logic [hpq_pkg::VALUE_WIDTH-1:0] a,
    input  logic [hpq_pkg::VALUE_WIDTH-1:0] b,
    output logic                            less
);

    // signed strict less-than
    assign less = $signed(a) < $signed(b);

endmodule

// File: sv/hpq_ctrl.sv
`timescale 1ns / 1ps

module hpq_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_opcode,
    input  logic [hpq_pkg::VALUE_WIDTH-1:0] in_value,
    output hpq_pkg::ram_req_t               ram_req,
    input  logic [hpq_pkg::VALUE_WIDTH-1:0] rd_a,
    input  logic [hpq_pkg::VALUE_WIDTH-1:0] rd_b,
    output logic [hpq_pkg::VALUE_WIDTH-1:0] cmp_a,
    output logic [hpq_pkg::VALUE_WIDTH-1:0] cmp_b,
    input  logic                            cmp_less,
    output hpq_pkg::res_t                   res,
    output logic                            res_valid,
    input  logic                            res_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_SEL,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [hpq_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic [hpq_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [hpq_pkg::VALUE_WIDTH-1:0]   val_reg, val_next;
    logic [hpq_pkg::VALUE_WIDTH-1:0]   top_reg, top_next;
    logic [hpq_pkg::VALUE_WIDTH-1:0]   popped_reg, popped_next;
    logic [hpq_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [hpq_pkg::VALUE_WIDTH-1:0]   best_reg, best_next;
    logic [hpq_pkg::ADDR_W-1:0]        best_idx_reg, best_idx_next;
    logic                              right_ok_reg, right_ok_next;

    logic [hpq_pkg::ADDR_W-1:0]        parent;
    logic [hpq_pkg::IDX_W-1:0]         left;
    logic [hpq_pkg::IDX_W-1:0]         right;
    logic [hpq_pkg::IDX_W-1:0]         cnt_ext;
    logic                              accept;

    assign parent  = (pos_reg - hpq_pkg::ADDR_W'(1)) >> 1;
    assign left    = {1'b0, pos_reg, 1'b1};
    assign right   = left + hpq_pkg::IDX_W'(1);
    assign cnt_ext = hpq_pkg::IDX_W'(cnt_reg);
    assign accept  = in_valid && in_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.popped_value  = popped_reg;
        res.top_value     = (cnt_reg != '0) ? top_reg : '0;
        res.element_total = hpq_pkg::TOTAL_W'(cnt_reg);
        res.is_empty      = (cnt_reg == '0);
        res.status        = status_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            S_DN_SEL:
            begin
                cmp_a = rd_b;
                cmp_b = rd_a;
            end
            S_DN_CMP:
            begin
                cmp_a = best_reg;
                cmp_b = val_reg;
            end
            default:
            begin
                cmp_a = val_reg;
                cmp_b = rd_a;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        right_ok_next = right_ok_reg;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = hpq_pkg::ST_OK;
                    popped_next = '0;
                    if (in_opcode == hpq_pkg::OP_PUSH)
                    begin
                        if (cnt_reg == hpq_pkg::CNT_W'(hpq_pkg::CAPACITY))
                        begin
                            status_next = hpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pos_next   = hpq_pkg::ADDR_W'(cnt_reg);
                            val_next   = in_value;
                            cnt_next   = cnt_reg + hpq_pkg::CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = hpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            popped_next = top_reg;
                            cnt_next    = cnt_reg - hpq_pkg::CNT_W'(1);
                            pos_next    = '0;
                            if (cnt_reg == hpq_pkg::CNT_W'(1))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                // fetch the last element
                                ram_req.raddr_a = hpq_pkg::ADDR_W'(cnt_reg - hpq_pkg::CNT_W'(1));
                                state_next      = S_POP_LD;
                            end
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = val_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    ram_req.raddr_a = parent;
                    state_next      = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_less)
                begin
                    ram_req.wdata = rd_a;
                    pos_next      = parent;
                    state_next    = S_UP_RD;
                end
                else
                begin
                    ram_req.wdata = val_reg;
                    state_next    = S_DONE;
                end
            end
            S_POP_LD:
            begin
                val_next   = rd_a;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (left >= cnt_ext)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = val_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    ram_req.raddr_a = hpq_pkg::ADDR_W'(left);
                    ram_req.raddr_b = hpq_pkg::ADDR_W'(right);
                    right_ok_next   = (right < cnt_ext);
                    state_next      = S_DN_SEL;
                end
            end
            S_DN_SEL:
            begin
                if (right_ok_reg && cmp_less)
                begin
                    best_next     = rd_b;
                    best_idx_next = hpq_pkg::ADDR_W'(right);
                end
                else
                begin
                    best_next     = rd_a;
                    best_idx_next = hpq_pkg::ADDR_W'(left);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_less)
                begin
                    ram_req.wdata = best_reg;
                    pos_next      = best_idx_reg;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    ram_req.wdata = val_reg;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow of the root entry
    assign top_next = (ram_req.we && ram_req.waddr == '0) ? ram_req.wdata : top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= hpq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        top_reg      <= top_next;
        popped_reg   <= popped_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        right_ok_reg <= right_ok_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hpq_pkg::CNT_W'(hpq_pkg::CAPACITY))
        else $error("element count beyond capacity");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> $stable(cnt_reg))
        else $error("element count changed during an operation");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (hpq_pkg::CNT_W'(ram_req.waddr) < cnt_reg))
        else $error("heap write beyond last element");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == hpq_pkg::OP_POP && cnt_reg == '0)
        |=> (state_reg == S_DONE && status_reg == hpq_pkg::ST_EMPTY))
        else $error("pop on empty queue not refused");

endmodule
